[rtl/core/tet_pkg.sv]
// ----------------------------------------------------------------------------
// tet_pkg
// Shared widths, register indexes, item types and controller codes for the
// threshold excursion tracker.
// ----------------------------------------------------------------------------
package tet_pkg;

	localparam int SET_DEPTH = 64;
	localparam int ID_BITS   = 64;

	localparam int E_W    = 32;
	localparam int CID_W  = 64;
	localparam int WAIT_W = 32;
	localparam int CLK_W  = 48;
	localparam int STEP_W = 32;
	localparam int DIST_W = 7;
	localparam int REC_W  = 16;

	localparam int CNT_W = $clog2(SET_DEPTH + 1);
	localparam int AW    = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_INHERENT  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_REC   = CFG_IDX_W'(3);

	localparam logic [REC_W-1:0] MAX_REC_RESET = '1;

	typedef struct packed {
		logic [E_W-1:0]    prev_energy;
		logic [E_W-1:0]    prev_energy_inherent;
		logic [E_W-1:0]    curr_energy;
		logic [E_W-1:0]    curr_energy_inherent;
		logic [CID_W-1:0]  config_id;
		logic [WAIT_W-1:0] dwell_time;
		logic [CLK_W-1:0]  sim_clock;
	} in_item_t;

	typedef struct packed {
		logic [E_W-1:0]    ridge_energy;
		logic [STEP_W-1:0] steps_above;
		logic [CLK_W-1:0]  time_above;
		logic [DIST_W-1:0] distinct_configs;
		logic              set_overflow;
		logic              same_energy;
		logic [CLK_W-1:0]  record_clock;
	} out_item_t;

	typedef struct packed {
		logic                  en;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	typedef enum logic [1:0] {
		CLS_NONE,
		CLS_UP,
		CLS_ABOVE,
		CLS_DOWN
	} cls_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SEARCH,
		ST_CLOSE
	} state_t;

	typedef struct packed {
		logic capture;
		logic latch_exit;
		logic track_peak;
		logic add_step;
		logic srch_start;
		logic srch_step;
		logic insert;
		logic emit;
		logic clear;
	} cmd_t;

	typedef struct packed {
		cls_t cls;
		logic first_exit;
		logic hit;
		logic miss;
	} sts_t;

endpackage

[rtl/core/tet_channels.sv]
// ----------------------------------------------------------------------------
// tet channels
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface tet_in_if;
	logic                     valid;
	logic                     ready;
	logic [tet_pkg::E_W-1:0]    prev_energy;
	logic [tet_pkg::E_W-1:0]    prev_energy_inherent;
	logic [tet_pkg::E_W-1:0]    curr_energy;
	logic [tet_pkg::E_W-1:0]    curr_energy_inherent;
	logic [tet_pkg::CID_W-1:0]  config_id;
	logic [tet_pkg::WAIT_W-1:0] dwell_time;
	logic [tet_pkg::CLK_W-1:0]  sim_clock;

	modport source (
		output valid, prev_energy, prev_energy_inherent, curr_energy,
		       curr_energy_inherent, config_id, dwell_time, sim_clock,
		input  ready
	);
	modport sink (
		input  valid, prev_energy, prev_energy_inherent, curr_energy,
		       curr_energy_inherent, config_id, dwell_time, sim_clock,
		output ready
	);
endinterface

interface tet_out_if;
	logic                     valid;
	logic                     ready;
	logic [tet_pkg::E_W-1:0]    ridge_energy;
	logic [tet_pkg::STEP_W-1:0] steps_above;
	logic [tet_pkg::CLK_W-1:0]  time_above;
	logic [tet_pkg::DIST_W-1:0] distinct_configs;
	logic                     set_overflow;
	logic                     same_energy;
	logic [tet_pkg::CLK_W-1:0]  record_clock;

	modport source (
		output valid, ridge_energy, steps_above, time_above, distinct_configs,
		       set_overflow, same_energy, record_clock,
		input  ready
	);
	modport sink (
		input  valid, ridge_energy, steps_above, time_above, distinct_configs,
		       set_overflow, same_energy, record_clock,
		output ready
	);
endinterface

interface tet_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [tet_pkg::CFG_IDX_W-1:0]  index;
	logic [tet_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/tet_ctrl.sv]
// ----------------------------------------------------------------------------
// tet_ctrl
// Controller: sequences capture, classification, id set search and record
// close, and owns the result valid flag.
// ----------------------------------------------------------------------------
module tet_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  tet_pkg::sts_t sts,
	output tet_pkg::cmd_t cmd
);

	tet_pkg::state_t state_q;
	tet_pkg::state_t state_nx;
	logic            out_valid_q;
	logic            out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			tet_pkg::ST_IDLE: begin
				if (in_valid)
					state_nx = tet_pkg::ST_EVAL;
			end
			tet_pkg::ST_EVAL: begin
				case (sts.cls)
					tet_pkg::CLS_UP,
					tet_pkg::CLS_ABOVE: state_nx = tet_pkg::ST_SEARCH;
					tet_pkg::CLS_DOWN:  state_nx = tet_pkg::ST_CLOSE;
					default:            state_nx = tet_pkg::ST_IDLE;
				endcase
			end
			tet_pkg::ST_SEARCH: begin
				if (sts.hit || sts.miss)
					state_nx = tet_pkg::ST_IDLE;
			end
			tet_pkg::ST_CLOSE: begin
				if (!sts.first_exit || out_free)
					state_nx = tet_pkg::ST_IDLE;
			end
			default: state_nx = tet_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			tet_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			tet_pkg::ST_EVAL: begin
				case (sts.cls)
					tet_pkg::CLS_UP: begin
						cmd.latch_exit = 1'b1;
						cmd.srch_start = 1'b1;
					end
					tet_pkg::CLS_ABOVE: begin
						cmd.track_peak = 1'b1;
						cmd.add_step   = 1'b1;
						cmd.srch_start = 1'b1;
					end
					tet_pkg::CLS_DOWN: begin
						cmd.add_step = 1'b1;
					end
					default: ;
				endcase
			end
			tet_pkg::ST_SEARCH: begin
				cmd.srch_step = 1'b1;
				cmd.insert    = sts.miss;
			end
			tet_pkg::ST_CLOSE: begin
				if (!sts.first_exit) begin
					cmd.clear = 1'b1;
				end else if (out_free) begin
					cmd.emit  = 1'b1;
					cmd.clear = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tet_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("record loaded over an untaken result");

	a_capture_eval: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == tet_pkg::ST_EVAL)
		else $error("captured item not evaluated");

	a_insert_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> !sts.hit && state_q == tet_pkg::ST_SEARCH)
		else $error("insert on a matching id");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.srch_start || cmd.insert) |-> !in_ready)
		else $error("input open while an item is at work");

endmodule

[rtl/core/tet_dp.sv]
// ----------------------------------------------------------------------------
// tet_dp
// Datapath: registers, item capture, threshold compare, peak, saturating
// step and time sums, distinct id store with its search, result register.
// ----------------------------------------------------------------------------
module tet_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  tet_pkg::cfg_wr_t   cfg_wr,
	input  tet_pkg::in_item_t  in_item,
	input  tet_pkg::cmd_t      cmd,
	output tet_pkg::sts_t      sts,
	output tet_pkg::out_item_t out_item
);

	// registers
	logic                         en_q;
	logic [tet_pkg::E_W-1:0]      thr_q;
	logic                         inh_q;
	logic [tet_pkg::REC_W-1:0]    maxrec_q;

	// captured item
	logic [tet_pkg::E_W-1:0]      prev_e_q;
	logic [tet_pkg::E_W-1:0]      prev_ei_q;
	logic [tet_pkg::E_W-1:0]      curr_e_q;
	logic [tet_pkg::E_W-1:0]      curr_ei_q;
	logic [tet_pkg::ID_BITS-1:0]  id_q;
	logic [tet_pkg::WAIT_W-1:0]   wait_q;
	logic [tet_pkg::CLK_W-1:0]    simclk_q;

	// excursion state
	logic [tet_pkg::E_W-1:0]      exit_q;
	logic [tet_pkg::E_W-1:0]      peak_q;
	logic [tet_pkg::STEP_W-1:0]   steps_q;
	logic [tet_pkg::CLK_W-1:0]    tsum_q;
	logic                         first_q;
	logic [tet_pkg::REC_W-1:0]    recs_q;
	logic [tet_pkg::CNT_W-1:0]    set_cnt_q;
	logic                         ovf_q;

	// id store and search
	logic [tet_pkg::ID_BITS-1:0]  mem [tet_pkg::SET_DEPTH];
	logic [tet_pkg::ID_BITS-1:0]  rd_q;
	logic [tet_pkg::CNT_W-1:0]    idx_q;
	logic                         pend_q;

	logic                         prev_hi;
	logic                         curr_hi;
	logic                         ignore;
	logic                         set_full;
	logic                         more;
	logic                         rd_en;
	tet_pkg::cls_t                cls;
	logic [tet_pkg::STEP_W-1:0]   steps_nx;
	logic [tet_pkg::CLK_W:0]      tsum_sum;
	logic [tet_pkg::CLK_W-1:0]    tsum_nx;
	logic [tet_pkg::E_W-1:0]      ret_e;

	assign prev_hi  = $signed(prev_e_q) >= $signed(thr_q);
	assign curr_hi  = $signed(curr_e_q) >= $signed(thr_q);
	assign ignore   = !en_q || (recs_q >= maxrec_q);
	assign set_full = set_cnt_q == tet_pkg::CNT_W'(tet_pkg::SET_DEPTH);
	assign more     = idx_q < set_cnt_q;

	always_comb begin
		cls = tet_pkg::CLS_NONE;
		if (!ignore) begin
			case ({prev_hi, curr_hi})
				2'b01:   cls = tet_pkg::CLS_UP;
				2'b11:   cls = tet_pkg::CLS_ABOVE;
				2'b10:   cls = tet_pkg::CLS_DOWN;
				default: cls = tet_pkg::CLS_NONE;
			endcase
		end
	end

	assign sts.cls        = cls;
	assign sts.first_exit = first_q;
	assign sts.hit        = pend_q && (rd_q == id_q);
	assign sts.miss       = !pend_q && !more;

	assign rd_en = cmd.srch_step && !sts.hit && more;

	assign steps_nx = (steps_q != '1) ? steps_q + 1'b1 : steps_q;
	assign tsum_sum = {1'b0, tsum_q} + (tet_pkg::CLK_W + 1)'(wait_q);
	assign tsum_nx  = tsum_sum[tet_pkg::CLK_W] ? '1 : tsum_sum[tet_pkg::CLK_W-1:0];
	assign ret_e    = inh_q ? curr_ei_q : curr_e_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			prev_e_q  <= in_item.prev_energy;
			prev_ei_q <= in_item.prev_energy_inherent;
			curr_e_q  <= in_item.curr_energy;
			curr_ei_q <= in_item.curr_energy_inherent;
			id_q      <= in_item.config_id[tet_pkg::ID_BITS-1:0];
			wait_q    <= in_item.dwell_time;
			simclk_q  <= in_item.sim_clock;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert && !set_full)
			mem[set_cnt_q[tet_pkg::AW-1:0]] <= id_q;
		if (rd_en)
			rd_q <= mem[idx_q[tet_pkg::AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_item.ridge_energy     <= peak_q;
			out_item.steps_above      <= steps_q;
			out_item.time_above       <= tsum_q;
			out_item.distinct_configs <= tet_pkg::DIST_W'(set_cnt_q);
			out_item.set_overflow     <= ovf_q;
			out_item.same_energy      <= ret_e == exit_q;
			out_item.record_clock     <= simclk_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q      <= 1'b0;
			thr_q     <= '0;
			inh_q     <= 1'b0;
			maxrec_q  <= tet_pkg::MAX_REC_RESET;
			exit_q    <= '0;
			peak_q    <= '0;
			steps_q   <= '0;
			tsum_q    <= '0;
			first_q   <= 1'b0;
			recs_q    <= '0;
			set_cnt_q <= '0;
			ovf_q     <= 1'b0;
			idx_q     <= '0;
			pend_q    <= 1'b0;
		end else begin
			if (cfg_wr.en) begin
				case (cfg_wr.index)
					tet_pkg::REG_ENABLE:    en_q     <= cfg_wr.data[0];
					tet_pkg::REG_THRESHOLD: thr_q    <= cfg_wr.data[tet_pkg::E_W-1:0];
					tet_pkg::REG_INHERENT:  inh_q    <= cfg_wr.data[0];
					tet_pkg::REG_MAX_REC:   maxrec_q <= cfg_wr.data[tet_pkg::REC_W-1:0];
					default: ;
				endcase
			end
			if (cmd.latch_exit) begin
				exit_q  <= inh_q ? prev_ei_q : prev_e_q;
				peak_q  <= curr_e_q;
				first_q <= 1'b1;
			end
			if (cmd.track_peak && ($signed(curr_e_q) > $signed(peak_q)))
				peak_q <= curr_e_q;
			if (cmd.add_step) begin
				steps_q <= steps_nx;
				tsum_q  <= tsum_nx;
			end
			if (cmd.srch_start) begin
				idx_q  <= '0;
				pend_q <= 1'b0;
			end else if (cmd.srch_step && !sts.hit) begin
				pend_q <= more;
				if (more)
					idx_q <= idx_q + 1'b1;
			end
			if (cmd.insert) begin
				if (set_full)
					ovf_q <= 1'b1;
				else
					set_cnt_q <= set_cnt_q + 1'b1;
			end
			if (cmd.emit)
				recs_q <= recs_q + 1'b1;
			if (cmd.clear) begin
				steps_q   <= '0;
				tsum_q    <= '0;
				set_cnt_q <= '0;
				ovf_q     <= 1'b0;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		set_cnt_q <= tet_pkg::CNT_W'(tet_pkg::SET_DEPTH))
		else $error("id count beyond store depth");

	a_hit_miss: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.srch_step |-> !(sts.hit && sts.miss))
		else $error("search both hit and missed");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> set_full)
		else $error("overflow flagged with room in the id store");

endmodule

[rtl/core/threshold_excursion_tracker.sv]
// ----------------------------------------------------------------------------
// threshold_excursion_tracker
// Tracks excursions of an energy trace above a threshold and emits one
// record for each closed excursion.
// ----------------------------------------------------------------------------
// in_ch takes one item at a time; ready is high only while the block is idle.
// Each item is captured and then classified; items below the threshold or
// ignored need no more. An item that ends above the threshold goes through
// the id store search, which reads one stored id per cycle through its
// single registered read port over the distinct ids held (at most 64); a
// downward crossing closes the record.
// out_ch carries a record from an output register, valid the cycle after
// the closing item's last step. The next item is taken while a record waits;
// a further record is held back until the receiver takes the pending one.
// cfg_ch writes registers by index (enable, threshold, inherent select, record
// limit) and is always ready; the user must write it only while idle, which
// the block does not enforce. Reset clears the registers to their defaults,
// all excursion state and the result valid flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
module threshold_excursion_tracker (
	input  logic       clk,
	input  logic       arst_n,
	tet_in_if.sink     in_ch,
	tet_out_if.source  out_ch,
	tet_cfg_if.sink    cfg_ch
);

	tet_pkg::cmd_t      cmd;
	tet_pkg::sts_t      sts;
	tet_pkg::in_item_t  in_item;
	tet_pkg::out_item_t out_item;
	tet_pkg::cfg_wr_t   cfg_wr;

	assign cfg_ch.ready = 1'b1;
	assign cfg_wr.en    = cfg_ch.valid;
	assign cfg_wr.index = cfg_ch.index;
	assign cfg_wr.data  = cfg_ch.data;

	assign in_item.prev_energy          = in_ch.prev_energy;
	assign in_item.prev_energy_inherent = in_ch.prev_energy_inherent;
	assign in_item.curr_energy          = in_ch.curr_energy;
	assign in_item.curr_energy_inherent = in_ch.curr_energy_inherent;
	assign in_item.config_id            = in_ch.config_id;
	assign in_item.dwell_time           = in_ch.dwell_time;
	assign in_item.sim_clock            = in_ch.sim_clock;

	assign out_ch.ridge_energy     = out_item.ridge_energy;
	assign out_ch.steps_above      = out_item.steps_above;
	assign out_ch.time_above       = out_item.time_above;
	assign out_ch.distinct_configs = out_item.distinct_configs;
	assign out_ch.set_overflow     = out_item.set_overflow;
	assign out_ch.same_energy      = out_item.same_energy;
	assign out_ch.record_clock     = out_item.record_clock;

	tet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tet_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_wr),
		.in_item  (in_item),
		.cmd      (cmd),
		.sts      (sts),
		.out_item (out_item)
	);

endmodule

[tb/sv/excursion_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// excursion_checker
// Watches the register, item and record channels of the threshold excursion
// tracker. It keeps its own copy of the registers and of the excursion state,
// works out the record that each accepted item closes, and compares every
// record taken from the block, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module excursion_checker
	import tet_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	tet_in_if    in_ch,
	tet_out_if   out_ch,
	tet_cfg_if   cfg_ch,
	output int   mismatches,
	output int   records_due,
	output int   records_made
);

	localparam logic [STEP_W-1:0] STEP_MAX = '1;
	localparam logic [CLK_W-1:0]  TIME_MAX = '1;

	logic                  track_on;
	logic signed [E_W-1:0] thr_level;
	logic                  inherent_sel;
	logic [REC_W-1:0]      record_limit;

	logic signed [E_W-1:0] exit_level;
	logic signed [E_W-1:0] peak_level;
	logic [STEP_W-1:0]     step_count;
	logic [CLK_W-1:0]      time_sum;
	logic                  exit_seen;
	logic [REC_W-1:0]      records_done;
	logic [ID_BITS-1:0]    id_store [SET_DEPTH];
	int                    id_count;
	logic                  id_full_hit;

	out_item_t             pending_records [$];

	function automatic void note_id(input logic [CID_W-1:0] raw);
		logic [ID_BITS-1:0] key;
		key = raw[ID_BITS-1:0];
		for (int i = 0; i < id_count; i++)
			if (id_store[i] == key) return;
		if (id_count < SET_DEPTH) begin
			id_store[id_count] = key;
			id_count++;
		end else begin
			id_full_hit = 1'b1;
		end
	endfunction

	function automatic void count_step(input logic [WAIT_W-1:0] dwell);
		logic [CLK_W:0] sum;
		if (step_count != STEP_MAX) step_count++;
		sum = {1'b0, time_sum} + (CLK_W+1)'(dwell);
		time_sum = sum[CLK_W] ? TIME_MAX : sum[CLK_W-1:0];
	endfunction

	function automatic bit track_item(input in_item_t it, output out_item_t rec);
		logic signed [E_W-1:0] pe;
		logic signed [E_W-1:0] ce;
		logic signed [E_W-1:0] cmp;
		bit                    prev_hi;
		bit                    curr_hi;
		bit                    emitted;
		rec = '0;
		emitted = 1'b0;
		if (!track_on || records_done >= record_limit) return 1'b0;
		pe = it.prev_energy;
		ce = it.curr_energy;
		prev_hi = pe >= thr_level;
		curr_hi = ce >= thr_level;
		if (!prev_hi && curr_hi) begin
			exit_level = inherent_sel ? it.prev_energy_inherent : it.prev_energy;
			peak_level = ce;
			note_id(it.config_id);
			exit_seen = 1'b1;
		end else if (prev_hi && curr_hi) begin
			if (ce > peak_level) peak_level = ce;
			count_step(it.dwell_time);
			note_id(it.config_id);
		end else if (prev_hi && !curr_hi) begin
			count_step(it.dwell_time);
			if (exit_seen) begin
				cmp = inherent_sel ? it.curr_energy_inherent : it.curr_energy;
				rec.ridge_energy     = peak_level;
				rec.steps_above      = step_count;
				rec.time_above       = time_sum;
				rec.distinct_configs = DIST_W'(id_count);
				rec.set_overflow     = id_full_hit;
				rec.same_energy      = (cmp == exit_level);
				rec.record_clock     = it.sim_clock;
				records_done++;
				emitted = 1'b1;
			end
			step_count = '0;
			time_sum = '0;
			id_count = 0;
			id_full_hit = 1'b0;
		end
		return emitted;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch: expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		out_item_t got;
		out_item_t rec;
		in_item_t  it;
		if (!arst_n) begin
			track_on = 1'b0;
			thr_level = '0;
			inherent_sel = 1'b0;
			record_limit = MAX_REC_RESET;
			exit_level = '0;
			peak_level = '0;
			step_count = '0;
			time_sum = '0;
			exit_seen = 1'b0;
			records_done = '0;
			id_count = 0;
			id_full_hit = 1'b0;
			pending_records.delete();
			mismatches = 0;
			records_due = 0;
			records_made = 0;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_ENABLE:    track_on = cfg_ch.data[0];
					REG_THRESHOLD: thr_level = cfg_ch.data;
					REG_INHERENT:  inherent_sel = cfg_ch.data[0];
					REG_MAX_REC:   record_limit = cfg_ch.data[REC_W-1:0];
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				got = {out_ch.ridge_energy, out_ch.steps_above, out_ch.time_above,
					out_ch.distinct_configs, out_ch.set_overflow, out_ch.same_energy,
					out_ch.record_clock};
				if (pending_records.size() == 0) begin
					$display("%0t ns: unexpected record: expected none, actual %h", $time, got);
					mismatches++;
				end else begin
					want = pending_records.pop_front();
					check_field("ridge_energy", want.ridge_energy, got.ridge_energy);
					check_field("steps_above", want.steps_above, got.steps_above);
					check_field("time_above", want.time_above, got.time_above);
					check_field("distinct_configs", want.distinct_configs,
						got.distinct_configs);
					check_field("set_overflow", want.set_overflow, got.set_overflow);
					check_field("same_energy", want.same_energy, got.same_energy);
					check_field("record_clock", want.record_clock, got.record_clock);
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				it = {in_ch.prev_energy, in_ch.prev_energy_inherent, in_ch.curr_energy,
					in_ch.curr_energy_inherent, in_ch.config_id, in_ch.dwell_time,
					in_ch.sim_clock};
				if (track_item(it, rec)) begin
					pending_records.push_back(rec);
					records_made++;
				end
			end
			records_due = pending_records.size();
		end
	end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the threshold excursion tracker with directed excursions (limits of
// the energies, threshold and record limit, inherent selection) and with
// random well-formed excursions, some long enough to fill the id set, mixed
// with noise, under random sender bursts and receiver stalls. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import tet_pkg::*;

	localparam int HALF_PERIOD  = 2;
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_CYCLES  = 600;
	localparam int PHASE_ITEMS  = 275;

	localparam logic signed [E_W-1:0] E_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [E_W-1:0] E_MIN = 32'sh8000_0000;

	logic clk;
	logic arst_n;
	logic long_hold;
	int   burst_left;
	int   items_sent;
	int   mismatches;
	int   records_due;
	int   records_made;
	logic signed [E_W-1:0] cur_thr;

	tet_in_if  in_if();
	tet_out_if out_if();
	tet_cfg_if cfg_if();

	threshold_excursion_tracker u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_if),
		.out_ch (out_if),
		.cfg_ch (cfg_if)
	);

	excursion_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_ch        (in_if),
		.out_ch       (out_if),
		.cfg_ch       (cfg_if),
		.mismatches   (mismatches),
		.records_due  (records_due),
		.records_made (records_made)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	initial begin
		#20_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		out_if.ready = 1'b0;
		long_hold = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				out_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold <= 1'b0;
			end else if ($urandom_range(0, 7) == 0) begin
				out_if.ready <= 1'b1;
				repeat ($urandom_range(50, 200)) @(posedge clk);
			end else begin
				out_if.ready <= ($urandom_range(0, 2) != 0);
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	task automatic send_item(input in_item_t it);
		if (burst_left == 0) begin
			in_if.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
				: $urandom_range(1, 24);
		end
		if (burst_left > 0) burst_left--;
		in_if.valid                <= 1'b1;
		in_if.prev_energy          <= it.prev_energy;
		in_if.prev_energy_inherent <= it.prev_energy_inherent;
		in_if.curr_energy          <= it.curr_energy;
		in_if.curr_energy_inherent <= it.curr_energy_inherent;
		in_if.config_id            <= it.config_id;
		in_if.dwell_time           <= it.dwell_time;
		in_if.sim_clock            <= it.sim_clock;
		@(posedge clk);
		while (!in_if.ready) @(posedge clk);
		items_sent++;
	endtask

	// hold the sender until every record is in and the block has gone quiet
	task automatic drain_and_wait();
		in_if.valid <= 1'b0;
		@(posedge clk);
		wait (records_due == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic en, input logic signed [E_W-1:0] thr,
			input logic inh, input logic [REC_W-1:0] limit);
		logic [CFG_IDX_W-1:0]  idx [4];
		logic [CFG_DATA_W-1:0] val [4];
		idx = '{REG_ENABLE, REG_THRESHOLD, REG_INHERENT, REG_MAX_REC};
		val = '{CFG_DATA_W'(en), thr, CFG_DATA_W'(inh), CFG_DATA_W'(limit)};
		for (int k = 0; k < 4; k++) begin
			cfg_if.valid <= 1'b1;
			cfg_if.index <= idx[k];
			cfg_if.data  <= val[k];
			@(posedge clk);
			while (!cfg_if.ready) @(posedge clk);
		end
		cfg_if.valid <= 1'b0;
		cur_thr = thr;
	endtask

	function automatic logic [E_W-1:0] energy_at(input bit high);
		longint base;
		longint off;
		off = ($urandom_range(0, 3) == 0) ? longint'($urandom & 32'h7FFF_FFFF)
			: longint'($urandom_range(0, 64));
		base = longint'(cur_thr);
		if (high) base = base + off;
		else base = base - 1 - off;
		if (base > longint'(E_MAX)) base = longint'(E_MAX);
		if (base < longint'(E_MIN)) base = longint'(E_MIN);
		return base[E_W-1:0];
	endfunction

	function automatic in_item_t noise_item();
		in_item_t it;
		it.prev_energy          = $urandom_range(0, 1) ? $urandom : energy_at($urandom_range(0, 1));
		it.prev_energy_inherent = $urandom;
		it.curr_energy          = $urandom_range(0, 1) ? $urandom : energy_at($urandom_range(0, 1));
		it.curr_energy_inherent = $urandom_range(0, 1) ? $urandom : energy_at($urandom_range(0, 1));
		it.config_id            = {$urandom, $urandom};
		it.dwell_time           = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0001_0000);
		it.sim_clock            = CLK_W'({$urandom, $urandom});
		return it;
	endfunction

	function automatic in_item_t make_item(input logic [E_W-1:0] pe, input logic [E_W-1:0] pi,
			input logic [E_W-1:0] ce, input logic [E_W-1:0] ci);
		in_item_t it;
		it = noise_item();
		it.prev_energy          = pe;
		it.prev_energy_inherent = pi;
		it.curr_energy          = ce;
		it.curr_energy_inherent = ci;
		return it;
	endfunction

	task automatic run_excursion(input int n_above, input bit fresh_ids);
		in_item_t         it;
		logic [CID_W-1:0] pool [4];
		logic [E_W-1:0]   exit_e;
		logic [E_W-1:0]   exit_i;
		logic [E_W-1:0]   last;
		foreach (pool[k]) pool[k] = {$urandom, $urandom};
		it = noise_item();
		it.prev_energy = energy_at(1'b0);
		it.curr_energy = energy_at(1'b1);
		it.config_id = pool[0];
		exit_e = it.prev_energy;
		exit_i = it.prev_energy_inherent;
		send_item(it);
		repeat (n_above) begin
			last = it.curr_energy;
			it = noise_item();
			it.prev_energy = last;
			it.curr_energy = energy_at(1'b1);
			if (!fresh_ids) it.config_id = pool[$urandom_range(0, 3)];
			send_item(it);
		end
		last = it.curr_energy;
		it = noise_item();
		it.prev_energy = last;
		it.curr_energy = ($urandom_range(0, 2) == 0) ? exit_e : energy_at(1'b0);
		if ($urandom_range(0, 2) == 0) it.curr_energy_inherent = exit_i;
		send_item(it);
	endtask

	task automatic random_phase(input logic signed [E_W-1:0] thr, input logic inh,
			input bit squeeze);
		in_item_t it;
		int       stop_at;
		drain_and_wait();
		program_regs(1'b1, thr, inh, MAX_REC_RESET);
		if (squeeze) long_hold <= 1'b1;
		stop_at = items_sent + PHASE_ITEMS;
		while (items_sent < stop_at) begin
			case ($urandom_range(0, 9))
				0: send_item(noise_item());
				1: begin
					it = noise_item();
					it.prev_energy = energy_at(1'b0);
					it.curr_energy = energy_at(1'b0);
					send_item(it);
				end
				default: begin
					if ($urandom_range(0, 24) == 0)
						run_excursion($urandom_range(62, 72), 1'b1);
					else
						run_excursion($urandom_range(0, 6), $urandom_range(0, 1));
				end
			endcase
		end
	endtask

	initial begin
		in_item_t it;
		arst_n = 1'b0;
		in_if.valid = 1'b0;
		in_if.prev_energy = '0;
		in_if.prev_energy_inherent = '0;
		in_if.curr_energy = '0;
		in_if.curr_energy_inherent = '0;
		in_if.config_id = '0;
		in_if.dwell_time = '0;
		in_if.sim_clock = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		burst_left = 0;
		items_sent = 0;
		cur_thr = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// disabled after reset: ignored
		repeat (3) send_item(noise_item());

		drain_and_wait();
		program_regs(1'b1, '0, 1'b0, MAX_REC_RESET);
		// above before any exit, closed without a record
		send_item(make_item(32'sh0005_0000, '0, 32'sh0007_0000, '0));
		send_item(make_item(32'sh0007_0000, '0, -32'sd65536, '0));
		send_item(make_item(E_MIN, '0, -32'sd1, '0));
		send_item(make_item(E_MIN, '0, '0, '0));
		it = make_item('0, '1, E_MAX, '1);
		it.dwell_time = '1;
		it.config_id = '1;
		it.sim_clock = '1;
		send_item(it);
		it = make_item(E_MAX, '0, 32'sh0001_0000, '0);
		it.dwell_time = '0;
		it.config_id = '0;
		it.sim_clock = '0;
		send_item(it);
		send_item(make_item(32'sh0001_0000, '0, E_MIN, '0));
		send_item(make_item(-32'sd1, '0, 32'sd1, '0));
		send_item(make_item(32'sd1, '0, -32'sd2, '0));

		drain_and_wait();
		program_regs(1'b1, E_MAX, 1'b1, MAX_REC_RESET);
		send_item(make_item(E_MAX - 1, 32'h1234_5678, E_MAX, '0));
		send_item(make_item(E_MAX, '0, '0, 32'h1234_5678));

		drain_and_wait();
		program_regs(1'b1, E_MIN, 1'b0, MAX_REC_RESET);
		repeat (2) send_item(noise_item());

		// exit latched from the plain energy, return compared on the inherent one
		drain_and_wait();
		program_regs(1'b1, '0, 1'b0, MAX_REC_RESET);
		send_item(make_item(-32'sd5, 32'sd7, 32'sd5, '0));
		drain_and_wait();
		program_regs(1'b1, '0, 1'b1, MAX_REC_RESET);
		send_item(make_item(32'sd5, '0, -32'sd9, -32'sd5));

		drain_and_wait();
		program_regs(1'b1, '0, 1'b0, '0);
		send_item(make_item(-32'sd3, '0, 32'sd3, '0));
		send_item(make_item(32'sd3, '0, -32'sd3, '0));

		drain_and_wait();
		program_regs(1'b1, '0, 1'b0, REC_W'(records_made + 1));
		repeat (2) begin
			send_item(make_item(-32'sd3, '0, 32'sd3, '0));
			send_item(make_item(32'sd3, '0, -32'sd3, '0));
		end

		random_phase('0, 1'b0, 1'b0);
		random_phase($urandom, 1'b1, 1'b1);
		random_phase(E_W'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000,
			$urandom_range(0, 1), 1'b0);
		random_phase($urandom, 1'b0, 1'b0);

		drain_and_wait();
		if (mismatches == 0 && records_due == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
